@@ rtl/chxy_pkg.sv @@
// shared types, constants and arctangent table for the compass heading block
package chxy_pkg;

   // default number of cordic iterations, and the arctangent table size
   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int ATAN_TABLE_LEN        = 24;
   localparam int IDX_W                 = 5;

   // input field width and fixed-point formats
   localparam int COMP_W         = 16;
   localparam int PRESCALE_SHIFT = 14;
   // datapath: magnitude stays below 2^31, one spare bit above that
   localparam int DATA_W         = 33;
   // angle accumulator in 1/256 centidegree, base plus full sum stays below 2^23
   localparam int ANGLE_W        = 25;
   localparam int ANGLE_FRAC_SH  = 8;
   // rounded centidegrees before wrapping
   localparam int CD_W           = 17;
   localparam int HEADING_W      = 16;

   localparam logic signed [ANGLE_W-1:0] HALF_TURN_UNITS = ANGLE_W'(4608000);
   localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_LSB  = ANGLE_W'(128);
   localparam logic signed [CD_W-1:0]    FULL_TURN_CD    = CD_W'(36000);

   // control that travels with each item down the pipeline
   typedef struct packed {
      logic valid;
      logic zero;
   } chxy_ctl_type;

   typedef logic signed [DATA_W-1:0]  data_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   // atan(2^-i) in 1/256 centidegree, rounded to nearest
   function automatic angle_type atan_units(input logic [IDX_W-1:0] idx);
      angle_type val;
      case (idx)
         5'd0:    val = ANGLE_W'(1152000);
         5'd1:    val = ANGLE_W'(680065);
         5'd2:    val = ANGLE_W'(359328);
         5'd3:    val = ANGLE_W'(182400);
         5'd4:    val = ANGLE_W'(91554);
         5'd5:    val = ANGLE_W'(45822);
         5'd6:    val = ANGLE_W'(22916);
         5'd7:    val = ANGLE_W'(11459);
         5'd8:    val = ANGLE_W'(5730);
         5'd9:    val = ANGLE_W'(2865);
         5'd10:   val = ANGLE_W'(1432);
         5'd11:   val = ANGLE_W'(716);
         5'd12:   val = ANGLE_W'(358);
         5'd13:   val = ANGLE_W'(179);
         5'd14:   val = ANGLE_W'(90);
         5'd15:   val = ANGLE_W'(45);
         5'd16:   val = ANGLE_W'(22);
         5'd17:   val = ANGLE_W'(11);
         5'd18:   val = ANGLE_W'(6);
         5'd19:   val = ANGLE_W'(3);
         5'd20:   val = ANGLE_W'(1);
         5'd21:   val = ANGLE_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/chxy_stage.sv @@
// one registered vectoring cordic iteration
module chxy_stage #(
   parameter int STAGE_IDX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  chxy_pkg::chxy_ctl_type   in_ctl,
   input  chxy_pkg::data_type       in_x,
   input  chxy_pkg::data_type       in_y,
   input  chxy_pkg::angle_type      in_z,
   output chxy_pkg::chxy_ctl_type   out_ctl,
   output chxy_pkg::data_type       out_x,
   output chxy_pkg::data_type       out_y,
   output chxy_pkg::angle_type      out_z
);

   chxy_pkg::chxy_ctl_type ctl_ff;
   chxy_pkg::data_type     x_ff, x_in;
   chxy_pkg::data_type     y_ff, y_in;
   chxy_pkg::angle_type    z_ff, z_in;
   chxy_pkg::data_type     dx, dy;
   chxy_pkg::angle_type    step_angle;

   // rotate toward the x axis, direction picked by the sign of y
   always_comb begin
      dx         = in_y >>> STAGE_IDX;
      dy         = in_x >>> STAGE_IDX;
      step_angle = chxy_pkg::atan_units(chxy_pkg::IDX_W'(STAGE_IDX));
      if (!in_y[chxy_pkg::DATA_W-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + step_angle;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - step_angle;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;

endmodule

@@ rtl/compass_heading_from_xy.sv @@
// compass heading: atan2(y, x) in centidegrees, 0..35999, by a pipelined cordic
// an item passes the entry register, the cordic stage registers and the output register
// throughput: one item per cycle; one register stage per cordic iteration
// busy is always low; rsp_valid strobes one cycle per item and the receiver cannot stall
// reset (synchronous, active high) clears the control bits only; data is not reset
module compass_heading_from_xy #(
   parameter int CORDIC_STAGES = chxy_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [chxy_pkg::COMP_W-1:0] req_comp_x,
   input  logic signed [chxy_pkg::COMP_W-1:0] req_comp_y,
   output logic                               rsp_valid,
   output logic [chxy_pkg::HEADING_W-1:0]     rsp_heading_centideg
);

   chxy_pkg::chxy_ctl_type stg_ctl [0:CORDIC_STAGES];
   chxy_pkg::data_type     stg_x   [0:CORDIC_STAGES];
   chxy_pkg::data_type     stg_y   [0:CORDIC_STAGES];
   chxy_pkg::angle_type    stg_z   [0:CORDIC_STAGES];

   chxy_pkg::chxy_ctl_type pre_ctl_ff, pre_ctl_in;
   chxy_pkg::data_type     pre_x_ff, pre_x_in;
   chxy_pkg::data_type     pre_y_ff, pre_y_in;
   chxy_pkg::angle_type    pre_z_ff, pre_z_in;
   chxy_pkg::data_type     xs, ys;

   logic                               rsp_valid_ff;
   logic [chxy_pkg::HEADING_W-1:0]     rsp_heading_ff, rsp_heading_in;
   chxy_pkg::angle_type                rounded;
   logic signed [chxy_pkg::CD_W-1:0]   cd, cd_wrap;

   assign busy = 1'b0;

   // entry stage: prescale, fold left half-plane into the right one
   always_comb begin
      xs = chxy_pkg::DATA_W'(req_comp_x) <<< chxy_pkg::PRESCALE_SHIFT;
      ys = chxy_pkg::DATA_W'(req_comp_y) <<< chxy_pkg::PRESCALE_SHIFT;
      pre_ctl_in.valid = start;
      pre_ctl_in.zero  = (req_comp_x == '0) && (req_comp_y == '0);
      if (req_comp_x[chxy_pkg::COMP_W-1]) begin
         pre_x_in = -xs;
         pre_y_in = -ys;
         pre_z_in = chxy_pkg::HALF_TURN_UNITS;
      end else begin
         pre_x_in = xs;
         pre_y_in = ys;
         pre_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ctl_ff <= '0;
      end else begin
         pre_ctl_ff <= pre_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      pre_x_ff <= pre_x_in;
      pre_y_ff <= pre_y_in;
      pre_z_ff <= pre_z_in;
   end

   assign stg_ctl[0] = pre_ctl_ff;
   assign stg_x[0]   = pre_x_ff;
   assign stg_y[0]   = pre_y_ff;
   assign stg_z[0]   = pre_z_ff;

   // cordic iterations, one register stage each
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      chxy_stage #(
         .STAGE_IDX (i)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .in_ctl  (stg_ctl[i]),
         .in_x    (stg_x[i]),
         .in_y    (stg_y[i]),
         .in_z    (stg_z[i]),
         .out_ctl (stg_ctl[i+1]),
         .out_x   (stg_x[i+1]),
         .out_y   (stg_y[i+1]),
         .out_z   (stg_z[i+1])
      );
   end

   // round to centidegrees and wrap into one turn; a zero input gives heading 0
   always_comb begin
      rounded = stg_z[CORDIC_STAGES] + chxy_pkg::ANGLE_HALF_LSB;
      cd      = chxy_pkg::CD_W'(rounded >>> chxy_pkg::ANGLE_FRAC_SH);
      if (cd[chxy_pkg::CD_W-1]) begin
         cd_wrap = cd + chxy_pkg::FULL_TURN_CD;
      end else if (cd >= chxy_pkg::FULL_TURN_CD) begin
         cd_wrap = cd - chxy_pkg::FULL_TURN_CD;
      end else begin
         cd_wrap = cd;
      end
      if (stg_ctl[CORDIC_STAGES].zero) begin
         rsp_heading_in = '0;
      end else begin
         rsp_heading_in = chxy_pkg::HEADING_W'(cd_wrap);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stg_ctl[CORDIC_STAGES].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_heading_ff <= rsp_heading_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_heading_centideg = rsp_heading_ff;

endmodule
